>>> hw/rtl/lvr_pkg.sv
// Shared constants and types for the leg vector Euler rotation core.
// No dependencies; every other file imports this package.

package lvr_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int TRIG_FRAC_DEF = 15;
	localparam int ANGLE_FIELD_W = 15;

	localparam int ANG_FULL = 23040;
	localparam int ANG_HALF = 11520;
	localparam int ANG_QUARTER = 5760;

	localparam longint PI_Q30 = 64'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

	// x = f * pi / 11520 in Q30, split into integer multiplier and remainder fraction
	localparam logic [30:0] X_INT_MUL = 31'(PI_Q30 / ANG_HALF);
	localparam logic [25:0] X_FRAC_NUM = 26'(PI_Q30 % ANG_HALF);
	localparam int X_RECIP_SH = 24;
	localparam logic [23:0] X_RECIP = 24'(((64'd1 << X_RECIP_SH) * (PI_Q30 % ANG_HALF)) / ANG_HALF);

	localparam int HORNER_STEPS = 5;
	localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};

	localparam int KERN_LAT = 20;
	localparam int SC_LAT = KERN_LAT + 2;
	localparam int MAT_LAT = 3;
	localparam int D_DLY = SC_LAT + MAT_LAT;
	localparam int E_DLY = D_DLY + 2;
	localparam int PIPE_LAT = E_DLY + 1;

	typedef enum logic [1:0] {
		QUAD_0 = 2'b00,
		QUAD_1 = 2'b01,
		QUAD_2 = 2'b10,
		QUAD_3 = 2'b11
	} quad_t;

endpackage

>>> hw/rtl/lvr_horner_step.sv
// One Horner step of the sine series: t' = 1 - floor(x2*t >> 30) / DIV, three stages.
// Depends on lvr_pkg.

module lvr_horner_step import lvr_pkg::*; #(
	parameter int unsigned DIV = 6
) (
	input  logic        clk,
	input  logic [30:0] x_in,
	input  logic [31:0] x2_in,
	input  logic [30:0] t_in,
	output logic [30:0] x_out,
	output logic [31:0] x2_out,
	output logic [30:0] t_out
);

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
	localparam logic [32:0] DIV_W = 33'(DIV);

	logic [62:0] prod_s1;
	logic [30:0] x_s1;
	logic [31:0] x2_s1;
	logic [31:0] p_s2;
	logic [29:0] q0_s2;
	logic [30:0] x_s2;
	logic [31:0] x2_s2;
	logic [30:0] x_s3;
	logic [31:0] x2_s3;
	logic [30:0] t_s3;

	logic [31:0] p;
	logic [63:0] qp;
	logic [32:0] rem;
	logic [30:0] q;

	assign p = prod_s1[61:30];
	assign qp = p * RECIP;
	assign rem = {1'b0, p_s2} - (33'(q0_s2) * DIV_W);
	assign q = {1'b0, q0_s2} + ((rem >= DIV_W) ? 31'd1 : 31'd0);

	always_ff @(posedge clk) begin
		prod_s1 <= x2_in * t_in;
		x_s1 <= x_in;
		x2_s1 <= x2_in;
		p_s2 <= p;
		q0_s2 <= qp[61:32];
		x_s2 <= x_s1;
		x2_s2 <= x2_s1;
		t_s3 <= ONE_Q30 - q;
		x_s3 <= x_s2;
		x2_s3 <= x2_s2;
	end

	assign x_out = x_s3;
	assign x2_out = x2_s3;
	assign t_out = t_s3;

endmodule

>>> hw/rtl/lvr_sin_kernel.sv
// Fixed-point sine of f * pi / 11520 for f in [0, 5760], KERN_LAT stages.
// Depends on lvr_pkg and lvr_horner_step.

module lvr_sin_kernel import lvr_pkg::*; #(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                    clk,
	input  logic [12:0]             f,
	output logic [TRIG_FRAC_BITS:0] sval
);

	localparam logic [25:0] HALF_W = 26'(ANG_HALF);
	localparam logic [32:0] RND = 33'd1 << (29 - TRIG_FRAC_BITS);

	logic [30:0] xi_s1;
	logic [25:0] a_s1;
	logic [12:0] q0_s1;
	logic [30:0] x_s2;
	logic [30:0] x_s3;
	logic [31:0] x2_s3;
	logic [61:0] prod_s4;
	logic [TRIG_FRAC_BITS:0] sval_s5;

	logic [36:0] qp;
	logic [25:0] rem;
	logic [12:0] q;
	logic [61:0] x2p;
	logic [32:0] rnd;

	logic [30:0] x_c [HORNER_STEPS+1];
	logic [31:0] x2_c [HORNER_STEPS+1];
	logic [30:0] t_c [HORNER_STEPS+1];

	assign qp = f * X_RECIP;
	assign rem = a_s1 - (q0_s1 * HALF_W);
	assign q = q0_s1 + ((rem >= HALF_W) ? 13'd1 : 13'd0);
	assign x2p = x_s2 * x_s2;

	assign x_c[0] = x_s3;
	assign x2_c[0] = x2_s3;
	assign t_c[0] = ONE_Q30;

	for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
		lvr_horner_step #(.DIV(HORNER_DIV[k])) u_step (
			.clk   (clk),
			.x_in  (x_c[k]),
			.x2_in (x2_c[k]),
			.t_in  (t_c[k]),
			.x_out (x_c[k+1]),
			.x2_out(x2_c[k+1]),
			.t_out (t_c[k+1])
		);
	end

	assign rnd = {1'b0, prod_s4[61:30]} + RND;

	always_ff @(posedge clk) begin
		xi_s1 <= f * X_INT_MUL;
		a_s1 <= f * X_FRAC_NUM;
		q0_s1 <= qp[36:24];
		x_s2 <= xi_s1 + {18'd0, q};
		x_s3 <= x_s2;
		x2_s3 <= x2p[61:30];
		prod_s4 <= x_c[HORNER_STEPS] * t_c[HORNER_STEPS];
		sval_s5 <= rnd[30-TRIG_FRAC_BITS +: TRIG_FRAC_BITS+1];
	end

	assign sval = sval_s5;

endmodule

>>> hw/rtl/lvr_sincos.sv
// Angle reduction, two sine kernels and quadrant mapping to signed sin and cos.
// Depends on lvr_pkg and lvr_sin_kernel.

module lvr_sincos import lvr_pkg::*; #(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                              clk,
	input  logic signed [ANGLE_FIELD_W-1:0]   angle,
	output logic signed [TRIG_FRAC_BITS+1:0]  sn,
	output logic signed [TRIG_FRAC_BITS+1:0]  cs
);

	localparam int TW = TRIG_FRAC_BITS + 2;

	logic signed [15:0] a16;
	logic [15:0] r;
	logic [12:0] f;
	quad_t quad;

	logic [12:0] f0_s1;
	logic [12:0] f1_s1;
	quad_t quad_s1;
	quad_t quad_dly [KERN_LAT];

	logic [TRIG_FRAC_BITS:0] s0;
	logic [TRIG_FRAC_BITS:0] s1;
	logic signed [TW-1:0] s0x;
	logic signed [TW-1:0] s1x;
	logic signed [TW-1:0] sn_q;
	logic signed [TW-1:0] cs_q;

	assign a16 = 16'(angle);
	assign r = (a16 < 0) ? 16'(a16 + 16'sd23040) : 16'(a16);

	always_comb begin
		priority if (r < 16'(ANG_QUARTER)) begin
			quad = QUAD_0;
			f = 13'(r);
		end else if (r < 16'(ANG_HALF)) begin
			quad = QUAD_1;
			f = 13'(r - 16'(ANG_QUARTER));
		end else if (r < 16'(ANG_HALF + ANG_QUARTER)) begin
			quad = QUAD_2;
			f = 13'(r - 16'(ANG_HALF));
		end else begin
			quad = QUAD_3;
			f = 13'(r - 16'(ANG_HALF + ANG_QUARTER));
		end
	end

	always_ff @(posedge clk) begin
		f0_s1 <= f;
		f1_s1 <= 13'(ANG_QUARTER) - f;
		quad_s1 <= quad;
		quad_dly[0] <= quad_s1;
		for (int i = 1; i < KERN_LAT; i++) begin
			quad_dly[i] <= quad_dly[i-1];
		end
	end

	lvr_sin_kernel #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_k0 (.clk(clk), .f(f0_s1), .sval(s0));
	lvr_sin_kernel #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_k1 (.clk(clk), .f(f1_s1), .sval(s1));

	assign s0x = signed'({1'b0, s0});
	assign s1x = signed'({1'b0, s1});

	always_ff @(posedge clk) begin
		unique case (quad_dly[KERN_LAT-1])
			QUAD_0: begin
				sn_q <= s0x;
				cs_q <= s1x;
			end
			QUAD_1: begin
				sn_q <= s1x;
				cs_q <= -s0x;
			end
			QUAD_2: begin
				sn_q <= -s0x;
				cs_q <= -s1x;
			end
			default: begin
				sn_q <= -s1x;
				cs_q <= s0x;
			end
		endcase
	end

	assign sn = sn_q;
	assign cs = cs_q;

endmodule

>>> hw/rtl/lvr_rot_matrix.sv
// R = Rx(roll) * Ry(pitch) * Rz(yaw), exact at 3F fraction bits, rounded to F.
// Depends on lvr_pkg.

module lvr_rot_matrix import lvr_pkg::*; #(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                             clk,
	input  logic signed [TRIG_FRAC_BITS+1:0] sr,
	input  logic signed [TRIG_FRAC_BITS+1:0] cr,
	input  logic signed [TRIG_FRAC_BITS+1:0] sp,
	input  logic signed [TRIG_FRAC_BITS+1:0] cp,
	input  logic signed [TRIG_FRAC_BITS+1:0] sy,
	input  logic signed [TRIG_FRAC_BITS+1:0] cy,
	output logic signed [TRIG_FRAC_BITS+2:0] r [3][3]
);

	localparam int F = TRIG_FRAC_BITS;
	localparam int TW = F + 2;
	localparam int RW = F + 3;
	localparam int P1W = 2 * TW;
	localparam int P2W = P1W + TW;
	localparam logic signed [P2W:0] BIAS2 = {{P2W{1'b0}}, 1'b1} << (2 * F - 1);
	localparam logic signed [P1W:0] BIAS1 = {{P1W{1'b0}}, 1'b1} << (F - 1);

	logic signed [P1W-1:0] srsp_s1, srcp_s1, crsp_s1, crcp_s1;
	logic signed [TW-1:0] sr_s1, cr_s1, sp_s1, cp_s1, sy_s1, cy_s1;
	logic signed [P1W-1:0] m [3][3];
	logic signed [P2W-1:0] pa_s2 [3];
	logic signed [P2W-1:0] pb_s2 [3];
	logic signed [P2W-1:0] pc_s2 [3];
	logic signed [P2W-1:0] pd_s2 [3];
	logic signed [P1W-1:0] m2_s2 [3];
	logic signed [P2W:0] sum0 [3];
	logic signed [P2W:0] sum1 [3];
	logic signed [P1W:0] sum2 [3];
	logic signed [RW-1:0] r_s3 [3][3];

	always_ff @(posedge clk) begin
		srsp_s1 <= sr * sp;
		srcp_s1 <= sr * cp;
		crsp_s1 <= cr * sp;
		crcp_s1 <= cr * cp;
		sr_s1 <= sr;
		cr_s1 <= cr;
		sp_s1 <= sp;
		cp_s1 <= cp;
		sy_s1 <= sy;
		cy_s1 <= cy;
	end

	always_comb begin
		m[0][0] = P1W'(cp_s1) <<< F;
		m[0][1] = '0;
		m[0][2] = P1W'(sp_s1) <<< F;
		m[1][0] = srsp_s1;
		m[1][1] = P1W'(cr_s1) <<< F;
		m[1][2] = -srcp_s1;
		m[2][0] = -crsp_s1;
		m[2][1] = P1W'(sr_s1) <<< F;
		m[2][2] = crcp_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s2[i] <= m[i][0] * cy_s1;
			pb_s2[i] <= m[i][1] * sy_s1;
			pc_s2[i] <= m[i][1] * cy_s1;
			pd_s2[i] <= m[i][0] * sy_s1;
			m2_s2[i] <= m[i][2];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum0[i] = (P2W+1)'(pa_s2[i]) + (P2W+1)'(pb_s2[i]) + BIAS2;
			sum1[i] = (P2W+1)'(pc_s2[i]) - (P2W+1)'(pd_s2[i]) + BIAS2;
			sum2[i] = (P1W+1)'(m2_s2[i]) + BIAS1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s3[i][0] <= sum0[i][2*F +: RW];
			r_s3[i][1] <= sum1[i][2*F +: RW];
			r_s3[i][2] <= sum2[i][F +: RW];
		end
	end

	assign r = r_s3;

endmodule

>>> hw/rtl/lvr_rotate.sv
// Rotate the motor offset by R, subtract from foot offset and saturate.
// Depends on lvr_pkg; three stages, d enters at the first and e at the third.

module lvr_rotate import lvr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                             clk,
	input  logic signed [TRIG_FRAC_BITS+2:0] r [3][3],
	input  logic signed [COORD_WIDTH:0]      d [3],
	input  logic signed [COORD_WIDTH:0]      e [3],
	output logic signed [COORD_WIDTH-1:0]    vec [3]
);

	localparam int F = TRIG_FRAC_BITS;
	localparam int CW = COORD_WIDTH;
	localparam int RW = F + 3;
	localparam int DW = CW + 1;
	localparam int PRW = RW + DW;
	localparam int ACW = PRW + 2;
	localparam int ROW = CW + 4;
	localparam int VW = CW + 5;
	localparam logic signed [ACW-1:0] BIAS = {{(ACW-1){1'b0}}, 1'b1} << (F - 1);
	localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [PRW-1:0] pr_s1 [3][3];
	logic signed [ACW-1:0] acc [3];
	logic signed [ROW-1:0] rot_s2 [3];
	logic signed [VW-1:0] v [3];
	logic signed [CW-1:0] vec_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pr_s1[i][j] <= r[i][j] * d[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACW'(pr_s1[i][0]) + ACW'(pr_s1[i][1]) + ACW'(pr_s1[i][2]) + BIAS;
			v[i] = VW'(e[i]) - VW'(rot_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rot_s2[i] <= acc[i][F +: ROW];
			if (v[i][VW-1:CW-1] == {(VW-CW+1){1'b0}} ||
				v[i][VW-1:CW-1] == {(VW-CW+1){1'b1}}) begin
				vec_s3[i] <= v[i][CW-1:0];
			end else if (v[i][VW-1]) begin
				vec_s3[i] <= VMIN;
			end else begin
				vec_s3[i] <= VMAX;
			end
		end
	end

	assign vec = vec_s3;

endmodule

>>> hw/rtl/leg_vector_euler_rotation_core.sv
// Top level of the leg vector Euler rotation core.
// Depends on lvr_pkg, lvr_sincos, lvr_rot_matrix and lvr_rotate.
//
//  channel  | handshake           | words
//  ---------+---------------------+----------------------------------------------
//  request  | start, busy         | roll/pitch/yaw_deg, motor_*, center_*, foot_*
//  result   | done (one cycle)    | vec_x, vec_y, vec_z
//
// One request per cycle; busy stays low. The pipeline depth is set by the 5-step sine
// series (3 stages each) followed by the matrix and rotate multiplier stages.
// Reset clears only the valid line; results cannot be stalled.

module leg_vector_euler_rotation_core import lvr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [ANGLE_FIELD_W-1:0] roll_deg,
	input  logic signed [ANGLE_FIELD_W-1:0] pitch_deg,
	input  logic signed [ANGLE_FIELD_W-1:0] yaw_deg,
	input  logic signed [COORD_WIDTH-1:0] motor_x,
	input  logic signed [COORD_WIDTH-1:0] motor_y,
	input  logic signed [COORD_WIDTH-1:0] motor_z,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic signed [COORD_WIDTH-1:0] foot_x,
	input  logic signed [COORD_WIDTH-1:0] foot_y,
	input  logic signed [COORD_WIDTH-1:0] foot_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] vec_x,
	output logic signed [COORD_WIDTH-1:0] vec_y,
	output logic signed [COORD_WIDTH-1:0] vec_z
);

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int CW = COORD_WIDTH;

	logic accept;
	logic [PIPE_LAT-1:0] vld_q;

	logic signed [CW:0] d_in [3];
	logic signed [CW:0] e_in [3];
	logic signed [CW:0] d_dly_q [D_DLY][3];
	logic signed [CW:0] e_dly_q [E_DLY][3];

	logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;
	logic signed [TW+0:0] r [3][3];
	logic signed [CW-1:0] vec [3];

	assign busy = 1'b0;
	assign accept = start && !busy;

	assign d_in[0] = (CW+1)'(motor_x) - (CW+1)'(center_x);
	assign d_in[1] = (CW+1)'(motor_y) - (CW+1)'(center_y);
	assign d_in[2] = (CW+1)'(motor_z) - (CW+1)'(center_z);
	assign e_in[0] = (CW+1)'(foot_x) - (CW+1)'(center_x);
	assign e_in[1] = (CW+1)'(foot_y) - (CW+1)'(center_y);
	assign e_in[2] = (CW+1)'(foot_z) - (CW+1)'(center_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		d_dly_q[0] <= d_in;
		e_dly_q[0] <= e_in;
		for (int i = 1; i < D_DLY; i++) begin
			d_dly_q[i] <= d_dly_q[i-1];
		end
		for (int i = 1; i < E_DLY; i++) begin
			e_dly_q[i] <= e_dly_q[i-1];
		end
	end

	lvr_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
		.clk(clk), .angle(roll_deg), .sn(sr), .cs(cr)
	);
	lvr_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
		.clk(clk), .angle(pitch_deg), .sn(sp), .cs(cp)
	);
	lvr_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
		.clk(clk), .angle(yaw_deg), .sn(sy), .cs(cy)
	);

	lvr_rot_matrix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mat (
		.clk(clk), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .r(r)
	);

	lvr_rotate #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot (
		.clk(clk),
		.r  (r),
		.d  (d_dly_q[D_DLY-1]),
		.e  (e_dly_q[E_DLY-1]),
		.vec(vec)
	);

	assign done = vld_q[PIPE_LAT-1];
	assign vec_x = vec[0];
	assign vec_y = vec[1];
	assign vec_z = vec[2];

endmodule

>>> hw/rtl/lvr_checker.sv
// Port-level checks for the leg vector Euler rotation core, bound to the top.
// Depends on lvr_pkg.

module lvr_checker import lvr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [COORD_WIDTH-1:0] motor_x,
	input logic signed [COORD_WIDTH-1:0] motor_y,
	input logic signed [COORD_WIDTH-1:0] motor_z,
	input logic signed [COORD_WIDTH-1:0] center_x,
	input logic signed [COORD_WIDTH-1:0] center_y,
	input logic signed [COORD_WIDTH-1:0] center_z,
	input logic signed [COORD_WIDTH-1:0] foot_x,
	input logic signed [COORD_WIDTH-1:0] foot_y,
	input logic signed [COORD_WIDTH-1:0] foot_z,
	input logic signed [COORD_WIDTH-1:0] vec_x,
	input logic signed [COORD_WIDTH-1:0] vec_y,
	input logic signed [COORD_WIDTH-1:0] vec_z
);

	a_never_busy: assert property (@(posedge clk) !busy)
		else $error("busy raised");

	a_word_returns: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("accepted word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without accepted word");

	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(motor_x == center_x && motor_y == center_y && motor_z == center_z &&
			foot_x == center_x && foot_y == center_y && foot_z == center_z, PIPE_LAT)
		|-> vec_x == 0 && vec_y == 0 && vec_z == 0)
		else $error("zero offsets gave nonzero vector");

endmodule

bind leg_vector_euler_rotation_core lvr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lvr_chk (.*);
